// ----- src/fixed_block_free_list_allocator_top_macros.svh -----
// Assertion macros shared by the allocator modules.
// Each macro expects the signals clk and arst_n to be in scope.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define FBFL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define FBFL_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FBFL_ASSERT(lbl, prop, msg)
`define FBFL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/fbfl_pkg.sv -----
package fbfl_pkg;

	// Default pool size limit; block indices are eight bits wide.
	localparam int MAX_BLOCKS_DEF = 256;
	localparam int IDX_LIMIT      = 256;

	// Field widths of the channels.
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 8;
	localparam int OFF_W      = 25;
	localparam int STAT_W     = 2;
	localparam int FREE_W     = 9;
	localparam int BCNT_W     = 9;
	localparam int BSIZE_W    = 17;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 17;

	// Configuration reset values.
	localparam logic [BCNT_W-1:0]  BCNT_RST  = 9'd256;
	localparam logic [BSIZE_W-1:0] BSIZE_RST = 17'd64;

	// Link header bytes in front of each payload.
	localparam int LINK_BYTES = 4;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INIT  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BLOCK_COUNT = 1'd0,
		REG_BLOCK_SIZE  = 1'd1
	} reg_index_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic finish;
		logic walk_start;
		logic walk_step;
		logic init_fin;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_init;
		logic walk_last;
	} stat_t;

endpackage

// ----- src/fbfl_if.sv -----
// Request channel: one allocator operation.
interface fbfl_req_if;
	logic                         valid;
	logic                         ready;
	logic [fbfl_pkg::KIND_W-1:0] kind;
	logic [fbfl_pkg::IDX_W-1:0]  block_index;

	modport source (output valid, output kind, output block_index, input ready);
	modport sink (input valid, input kind, input block_index, output ready);
endinterface

// Response channel: one result per request.
interface fbfl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [fbfl_pkg::IDX_W-1:0]  granted_index;
	logic [fbfl_pkg::OFF_W-1:0]  granted_offset;
	logic [fbfl_pkg::STAT_W-1:0] status;
	logic [fbfl_pkg::FREE_W-1:0] free_left;

	modport source (output valid, output granted_index, output granted_offset,
		output status, output free_left, input ready);
	modport sink (input valid, input granted_index, input granted_offset,
		input status, input free_left, output ready);
endinterface

// Configuration write channel.
interface fbfl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [fbfl_pkg::CFG_ADDR_W-1:0] index;
	logic [fbfl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/fbfl_dp.sv -----
`include "fixed_block_free_list_allocator_top_macros.svh"

module fbfl_dp #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fbfl_pkg::cmd_t                   cmd,
	output fbfl_pkg::stat_t                  stat,
	input  logic [fbfl_pkg::KIND_W-1:0]      in_kind,
	input  logic [fbfl_pkg::IDX_W-1:0]       in_index,
	input  logic                             cfg_we,
	input  logic [fbfl_pkg::CFG_ADDR_W-1:0]  cfg_index,
	input  logic [fbfl_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [fbfl_pkg::IDX_W-1:0]       granted_index,
	output logic [fbfl_pkg::OFF_W-1:0]       granted_offset,
	output logic [fbfl_pkg::STAT_W-1:0]      status,
	output logic [fbfl_pkg::FREE_W-1:0]      free_left
);

	localparam int DEPTH  = (MAX_BLOCKS < fbfl_pkg::IDX_LIMIT) ? MAX_BLOCKS
		: fbfl_pkg::IDX_LIMIT;
	localparam int LINK_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PROD_W = LINK_W + fbfl_pkg::BSIZE_W + 1;

	// Architectural state and configuration.
	logic [LINK_W-1:0]            head_q;
	logic [CNT_W-1:0]             count_q;
	logic [fbfl_pkg::BCNT_W-1:0]  bcount_q;
	logic [fbfl_pkg::BSIZE_W-1:0] bsize_q;

	// Latched request and work registers.
	fbfl_pkg::kind_t             kind_q;
	logic [fbfl_pkg::IDX_W-1:0]  idx_q;
	logic [fbfl_pkg::OFF_W-1:0]  offset_s1;
	logic [LINK_W-1:0]           walk_q;
	logic [LINK_W-1:0]           link_rd_q;

	// Result registers.
	logic [LINK_W-1:0]           gidx_q;
	logic [fbfl_pkg::OFF_W-1:0]  goff_q;
	fbfl_pkg::status_t           stat_q;
	logic [CNT_W-1:0]            free_q;

	// Link memory.
	logic [LINK_W-1:0] link_mem [DEPTH];

	logic [CNT_W-1:0]            n_eff;
	logic                        walk_last;
	logic [fbfl_pkg::BSIZE_W:0]  stride;
	logic [PROD_W-1:0]           prod;
	logic                        mem_re;
	logic                        mem_we;
	logic [LINK_W-1:0]           mem_waddr;
	logic [LINK_W-1:0]           mem_wdata;
	logic [LINK_W-1:0]           head_nxt;
	logic [CNT_W-1:0]            count_nxt;
	logic [LINK_W-1:0]           res_idx;
	logic [fbfl_pkg::OFF_W-1:0]  res_off;
	fbfl_pkg::status_t           res_st;
	logic                        load_out;

	// Effective block count, limited to one up to the pool depth.
	always_comb begin
		if (bcount_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (bcount_q > fbfl_pkg::BCNT_W'(DEPTH)) begin
			n_eff = CNT_W'(DEPTH);
		end else begin
			n_eff = CNT_W'(bcount_q);
		end
	end

	assign walk_last      = (walk_q == LINK_W'(n_eff - CNT_W'(1)));
	assign stat.walk_last = walk_last;
	assign stat.is_init   = (kind_q == fbfl_pkg::KIND_INIT);

	// Offset of the current head: index * (size + link bytes) + link bytes.
	assign stride = {1'b0, bsize_q} + (fbfl_pkg::BSIZE_W + 1)'(fbfl_pkg::LINK_BYTES);
	assign prod   = PROD_W'(head_q) * PROD_W'(stride);

	assign mem_re   = cmd.capture && (fbfl_pkg::kind_t'(in_kind) == fbfl_pkg::KIND_ALLOC);
	assign load_out = cmd.finish || cmd.init_fin;

	// Next list state, memory write and result of the finishing step.
	always_comb begin
		head_nxt  = head_q;
		count_nxt = count_q;
		res_idx   = '0;
		res_off   = '0;
		res_st    = fbfl_pkg::ST_OK;
		mem_we    = 1'b0;
		mem_waddr = walk_q;
		mem_wdata = walk_last ? '0 : LINK_W'(walk_q + LINK_W'(1));
		if (cmd.walk_step) begin
			mem_we = 1'b1;
		end
		if (cmd.init_fin) begin
			head_nxt  = '0;
			count_nxt = n_eff;
		end
		if (cmd.finish) begin
			unique case (kind_q)
				fbfl_pkg::KIND_ALLOC: begin
					if (count_q == '0) begin
						res_st = fbfl_pkg::ST_EMPTY;
					end else begin
						res_idx   = head_q;
						res_off   = offset_s1;
						head_nxt  = link_rd_q;
						count_nxt = count_q - CNT_W'(1);
					end
				end
				fbfl_pkg::KIND_FREE: begin
					if ((count_q >= n_eff) ||
						(fbfl_pkg::BCNT_W'(idx_q) >= fbfl_pkg::BCNT_W'(n_eff))) begin
						res_st = fbfl_pkg::ST_REJECT;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = idx_q[LINK_W-1:0];
						mem_wdata = head_q;
						head_nxt  = idx_q[LINK_W-1:0];
						count_nxt = count_q + CNT_W'(1);
					end
				end
				fbfl_pkg::KIND_INIT: begin
					res_st = fbfl_pkg::ST_OK;
				end
				fbfl_pkg::KIND_NOP: begin
					res_st = fbfl_pkg::ST_OK;
				end
			endcase
		end
	end

	// List state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			bcount_q <= fbfl_pkg::BCNT_RST;
			bsize_q  <= fbfl_pkg::BSIZE_RST;
		end else begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
			if (cfg_we) begin
				unique case (fbfl_pkg::reg_index_t'(cfg_index))
					fbfl_pkg::REG_BLOCK_COUNT: bcount_q <= fbfl_pkg::BCNT_W'(cfg_data);
					fbfl_pkg::REG_BLOCK_SIZE:  bsize_q  <= fbfl_pkg::BSIZE_W'(cfg_data);
				endcase
			end
		end
	end

	// Request latch, offset stage, walk counter and result registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= fbfl_pkg::kind_t'(in_kind);
			idx_q     <= in_index;
			offset_s1 <= fbfl_pkg::OFF_W'(prod) + fbfl_pkg::OFF_W'(fbfl_pkg::LINK_BYTES);
		end
		if (cmd.walk_start) begin
			walk_q <= '0;
		end else if (cmd.walk_step) begin
			walk_q <= LINK_W'(walk_q + LINK_W'(1));
		end
		if (load_out) begin
			gidx_q <= res_idx;
			goff_q <= res_off;
			stat_q <= res_st;
			free_q <= count_nxt;
		end
	end

	// Link memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			link_rd_q <= link_mem[head_q];
		end
	end

	assign granted_index  = fbfl_pkg::IDX_W'(gidx_q);
	assign granted_offset = goff_q;
	assign status         = stat_q;
	assign free_left      = fbfl_pkg::FREE_W'(free_q);

	`FBFL_ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH), "free count above pool depth")
	`FBFL_ASSERT(a_init_result,
		cmd.init_fin |=> (head_q == '0) && (count_q == $past(n_eff)),
		"init did not rebuild the list")
	`FBFL_ASSERT(a_pop_count,
		(cmd.finish && (kind_q == fbfl_pkg::KIND_ALLOC) && (count_q != '0))
		|=> (count_q == $past(count_q) - CNT_W'(1)),
		"alloc did not take one block")

endmodule

// ----- src/fbfl_ctrl.sv -----
`include "fixed_block_free_list_allocator_top_macros.svh"

module fbfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  fbfl_pkg::stat_t stat,
	output fbfl_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_INIT_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// The result register can take a new result when empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands to the datapath for the current state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_EXEC: begin
				if (stat.is_init) begin
					cmd.walk_start = 1'b1;
				end else if (slot_free) begin
					cmd.finish = 1'b1;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
			end
			S_INIT_FIN: begin
				cmd.init_fin = slot_free;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish || cmd.init_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (stat.is_init) begin
						state_q <= S_WALK;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (stat.walk_last) begin
						state_q <= S_INIT_FIN;
					end
				end
				S_INIT_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	`FBFL_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_q == S_EXEC), "accepted request not taken up")
	`FBFL_ASSERT(a_load_into_free_slot, (cmd.finish || cmd.init_fin) |-> slot_free, "result overwrote a waiting result")
	`FBFL_ASSERT(a_walk_continues, ((state_q == S_WALK) && !stat.walk_last) |=> (state_q == S_WALK), "init walk ended early")

endmodule

// ----- src/fixed_block_free_list_allocator_top.sv -----
// Fixed-size block pool allocator with a singly linked free list held in an
// on-chip link memory. A request of kind alloc pops the head block and
// returns its index and byte offset, kind free pushes a block back, kind
// init relinks blocks 0 to count-1 in order, and the fourth kind does
// nothing. Every request gives exactly one response. Alloc, free and the
// idle kind finish from the exec state once the output register is free;
// alloc takes the head's successor from the registered read of the link
// memory. Init writes one link per cycle through the single write port.
// One request is in work at a time; a finished response waits in the
// output register while the next request is accepted. No clearing pass
// is needed after reset: the free count resets to zero, so the pool holds
// no blocks until an init or a free. Configuration writes are always taken
// and must only be made while no request is outstanding.
module fixed_block_free_list_allocator_top #(
	parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fbfl_req_if.sink   req,
	fbfl_rsp_if.source rsp,
	fbfl_cfg_if.sink   cfg
);

	fbfl_pkg::cmd_t  cmd;
	fbfl_pkg::stat_t stat;

	// Configuration registers accept a write in every cycle.
	assign cfg.ready = 1'b1;

	fbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbfl_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_kind        (req.kind),
		.in_index       (req.block_index),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.granted_index  (rsp.granted_index),
		.granted_offset (rsp.granted_offset),
		.status         (rsp.status),
		.free_left      (rsp.free_left)
	);

endmodule
